// File: rtl/maf_pkg.sv
// Shared types for the moving average filter.
// No dependencies; imported by maf_front, maf_back and the top level.
package maf_pkg;

  // Kind of a queued command, taken from the action field of an input word
  typedef enum logic {
    OP_PRIME  = 1'b0,
    OP_SAMPLE = 1'b1
  } maf_op_e;

  // Status from the back end to the front end
  typedef struct packed {
    logic clearing;
  } maf_ctl_t;

endpackage

// File: rtl/maf_front.sv
// Front end of the moving average filter: input handshake, classification
// and a two-entry command queue toward the back end. Depends on maf_pkg.
module maf_front #(
  parameter int SAMPLE_BITS = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  maf_pkg::maf_ctl_t      ctl_i,
  input  logic                   cmd_pop_i,
  output logic                   cmd_valid_o,
  output maf_pkg::maf_op_e       cmd_op_o,
  output logic [SAMPLE_BITS-1:0] cmd_value_o
);
  import maf_pkg::*;

  localparam int Depth = 2;

  maf_op_e                op_q  [Depth];
  logic [SAMPLE_BITS-1:0] val_q [Depth];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;
  logic                   push, pop, full;
  maf_op_e                op_in;

  assign full       = (count_q == 2'(Depth));
  // Hold off new words while the queue is full or the ring is being cleared after reset
  assign in_stall_o = full | ctl_i.clearing;
  assign push       = in_valid_i & ~in_stall_o;
  assign pop        = cmd_pop_i & cmd_valid_o;

  always_comb begin
    unique case (action_i)
      1'b0:    op_in = OP_PRIME;
      default: op_in = OP_SAMPLE;
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= op_in;
      val_q[wr_ptr_q] <= sample_i;
    end
  end

  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_op_o    = op_q[rd_ptr_q];
  assign cmd_value_o = val_q[rd_ptr_q];

endmodule

// File: rtl/maf_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies; used by maf_back.
module maf_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial, diff;
  logic             take;

  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign take  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NUM_W-2:0], take};
      rem_q  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/maf_back.sv
// Back end of the moving average filter: sample ring, running sum, ring
// index, divide and result register. Depends on maf_pkg and maf_div.
module maf_back #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     len_i,
  input  logic                                cmd_valid_i,
  input  maf_pkg::maf_op_e                    cmd_op_i,
  input  logic [SAMPLE_BITS-1:0]              cmd_value_i,
  output logic                                cmd_pop_o,
  output maf_pkg::maf_ctl_t                   ctl_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [SAMPLE_BITS-1:0]              average_o
);
  import maf_pkg::*;

  localparam int IdxW = $clog2(MAX_WINDOW);
  localparam int LenW = $clog2(MAX_WINDOW + 1);
  localparam longint SumNeed = longint'(MAX_WINDOW) *
                               ((longint'(1) << SAMPLE_BITS) - longint'(1));
  localparam int SumW = $clog2(SumNeed + longint'(1));

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_UPDATE,
    ST_DIV_GO,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                 state_q, state_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [IdxW-1:0]        addr_q, addr_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic                   we;
  logic [IdxW-1:0]        waddr;
  logic [SAMPLE_BITS-1:0] wdata;

  logic [LenW-1:0]             len_dec;
  logic [IdxW-1:0]             len_m1, idx_next;
  logic [LenW+SAMPLE_BITS-1:0] prod;
  logic                        div_start, div_done;
  logic [SumW-1:0]             quot;

  assign len_dec  = len_i - LenW'(1);
  assign len_m1   = len_dec[IdxW-1:0];
  assign idx_next = ((idx_q == '0) || (LenW'(idx_q) >= len_i)) ? len_m1 : idx_q - 1'b1;
  assign prod     = (LenW+SAMPLE_BITS)'(len_i) * (LenW+SAMPLE_BITS)'(cmd_value_i);

  maf_div #(
    .NUM_W (SumW),
    .DEN_W (LenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (len_i),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    addr_d    = addr_q;
    sum_d     = sum_q;
    smp_d     = smp_q;
    avg_d     = avg_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = smp_q;
    cmd_pop_o = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        if (addr_q == IdxW'(MAX_WINDOW - 1)) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          smp_d     = cmd_value_i;
          unique case (cmd_op_i)
            OP_PRIME: begin
              sum_d   = prod[SumW-1:0];
              idx_d   = len_m1;
              addr_d  = '0;
              state_d = ST_FILL;
            end
            default: begin
              // The ring read at idx_next lands in rdata_q next cycle
              idx_d   = idx_next;
              state_d = ST_UPDATE;
            end
          endcase
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (addr_q == len_m1) begin
          state_d = ST_DIV_GO;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_UPDATE: begin
        we      = 1'b1;
        waddr   = idx_q;
        sum_d   = sum_q + SumW'(smp_q) - SumW'(rdata_q);
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          avg_d   = (quot > SumW'({SAMPLE_BITS{1'b1}})) ? {SAMPLE_BITS{1'b1}}
                                                        : quot[SAMPLE_BITS-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= IdxW'(MAX_WINDOW - 1);
      addr_q  <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      addr_q  <= addr_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    avg_q <= avg_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      ring[waddr] <= wdata;
    end
    rdata_q <= ring[idx_next];
  end

  assign ctl_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o    = (state_q == ST_OUT);
  assign average_o      = avg_q;

endmodule

// File: rtl/moving_average_filter_top.sv
// Top level of the box-car moving average filter.
// Depends on maf_pkg, maf_front, maf_div and maf_back.
//
// Box-car moving average over the last window_length samples. A word with
// action 0 primes the whole window with its sample value; a word with
// action 1 pushes a new sample into the ring, replacing the oldest one. Each
// word returns one average word: floor(running sum / window length),
// clamped at full scale. A sample word waits on the one-bit-per-cycle
// divider on the running sum; a prime word also fills the ring memory
// one entry per cycle through its single write port, before the divide.
// Words are served one at a time; a two-entry queue in front keeps
// accepting while a result waits on the output. After reset the ring is
// cleared, and while that lasts no input word is accepted; configuration
// writes are taken as usual. Write the window length only while idle;
// 0 saturates to 1 and values above MAX_WINDOW saturate to MAX_WINDOW.
// The length resets to MAX_WINDOW.
module moving_average_filter_top #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  // Result words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [SAMPLE_BITS-1:0]          average_o,
  // Window length register
  input  logic                            cfg_we_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] cfg_data_i
);
  import maf_pkg::*;

  localparam int LenW = $clog2(MAX_WINDOW + 1);

  logic [LenW-1:0]        len_q, len_d;
  maf_ctl_t               ctl;
  logic                   cmd_valid, cmd_pop;
  maf_op_e                cmd_op;
  logic [SAMPLE_BITS-1:0] cmd_value;

  // Saturate the written length into 1..MAX_WINDOW
  always_comb begin
    len_d = len_q;
    if (cfg_we_i) begin
      priority if (cfg_data_i == '0) begin
        len_d = LenW'(1);
      end else if (cfg_data_i > LenW'(MAX_WINDOW)) begin
        len_d = LenW'(MAX_WINDOW);
      end else begin
        len_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(MAX_WINDOW);
    end else begin
      len_q <= len_d;
    end
  end

  // Accept and classify words, queue them toward the back end
  maf_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .ctl_i       (ctl),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_op_o    (cmd_op),
    .cmd_value_o (cmd_value)
  );

  // Ring update, running sum, divide and result register
  maf_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len_q),
    .cmd_valid_i (cmd_valid),
    .cmd_op_i    (cmd_op),
    .cmd_value_i (cmd_value),
    .cmd_pop_o   (cmd_pop),
    .ctl_o       (ctl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for moving_average_filter_top, the box-car average.
// Depends on maf_pkg and the filter RTL; a scoreboard class predicts each average word.
`timescale 1ns / 100ps

module testbench;
  import maf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int unsigned RANDOM_WORDS = 1550;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam logic [13:0] FULL_SCALE   = 14'h3fff;

  // One input word: the operation and its sample (or priming value)
  typedef struct packed {
    maf_op_e     op;
    logic [13:0] smp;
  } filter_word_t;

  // Predicts the filter: own copy of the ring, the running sum, the write
  // index and the window length, plus the averages still owed by the block.
  class average_scoreboard;
    localparam int unsigned MAX_LEN = 256;
    localparam logic [21:0] SUM_FULL_SCALE = 22'd16383;

    logic [13:0] ring [MAX_LEN];
    logic [21:0] sum;
    int unsigned idx;
    int unsigned len;
    logic [13:0] due [$];

    function new();
      for (int i = 0; i < MAX_LEN; i++) ring[i] = '0;
      sum = '0;
      idx = MAX_LEN - 1;
      len = MAX_LEN;
    endfunction

    // Saturate the written value into 1..MAX_LEN, as the register does
    function void set_length(int unsigned raw);
      if (raw < 1) len = 1;
      else if (raw > MAX_LEN) len = MAX_LEN;
      else len = raw;
    endfunction

    // Apply one accepted word and queue the average it must produce
    function void note_word(logic act, logic [13:0] smp);
      logic [21:0] q;
      if (maf_op_e'(act) == OP_PRIME) begin
        for (int i = 0; i < len; i++) ring[i] = smp;
        sum = 22'(len * smp);
        idx = len - 1;
      end else begin
        if (idx == 0 || idx >= len) idx = len - 1;
        else idx--;
        // Plain 22-bit adder: wraps when the sum is out of step with the ring
        sum = sum + 22'(smp) - 22'(ring[idx]);
        ring[idx] = smp;
      end
      q = sum / 22'(len);
      due.push_back((q > SUM_FULL_SCALE) ? 14'h3fff : q[13:0]);
    endfunction

    // Compare one accepted average word with the oldest one owed
    function bit check_average(logic [13:0] got, output string why);
      logic [13:0] want;
      if (due.size() == 0) begin
        why = $sformatf("average %0d arrived with none outstanding", got);
        return 1'b0;
      end
      want = due.pop_front();
      if (got !== want) begin
        why = $sformatf("average is %0d, predicted %0d", got, want);
        return 1'b0;
      end
      why = "";
      return 1'b1;
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        action_i;
  logic [13:0] sample_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [13:0] average_o;
  logic        cfg_we_i;
  logic [8:0]  cfg_data_i;

  average_scoreboard sb = new();
  filter_word_t      plan [$];
  int unsigned       errors = 0;
  int unsigned       cycles = 0;

  always #5 clk_i = ~clk_i;

  moving_average_filter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string why);
    errors++;
    if (errors <= MAX_REPORTS) $display("tb: mismatch at cycle %0d: %s", cycles, why);
  endtask

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Watch both handshakes with the values from before the edge
  always @(posedge clk_i) begin : monitor
    string why;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_word(action_i, sample_i);
      if (out_valid_o && !out_stall_i) begin
        if (!sb.check_average(average_o, why)) report_mismatch(why);
      end
    end
  end

  // Receiver: free runs of random length (now and then very long ones)
  // broken by stall runs of random length.
  initial begin : receiver
    int free_run;
    int hold;
    forever begin
      free_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 600)
                                             : $urandom_range(1, 40);
      out_stall_i <= 1'b0;
      repeat (free_run) @(posedge clk_i);
      hold = $urandom_range(1, 12);
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
    end
  end

  // Present one word and hold it until the filter takes it
  task automatic send_word(input filter_word_t w);
    in_valid_i <= 1'b1;
    action_i   <= w.op;
    sample_i   <= w.smp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Advance at least one cycle, then until no average is outstanding
  task automatic wait_idle();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Write the window length; the scoreboard saturates it the same way
  task automatic write_length(input int unsigned raw);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= 9'(raw);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_length(raw);
    @(posedge clk_i);
  endtask

  function automatic void queue_word(input maf_op_e op, input logic [13:0] smp);
    plan.push_back('{op, smp});
  endfunction

  // Favor the ends of the sample range, otherwise any value
  function automatic logic [13:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FULL_SCALE;
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  // Send the planned words in bursts with optional gaps, optionally drain halfway,
  // then wait until every average has come back so the block is idle.
  task automatic play_plan(input bit gaps_on, input bit drain_mid);
    int n;
    int left;
    int gap;
    n = plan.size();
    left = $urandom_range(1, 16);
    for (int k = 0; k < n; k++) begin
      send_word(plan[k]);
      if (k == n - 1) begin
        in_valid_i <= 1'b0;
      end else if (drain_mid && k == n / 2) begin
        // hold off the sender until the filter has answered everything
        in_valid_i <= 1'b0;
        wait_idle();
      end else begin
        left--;
        if (left == 0) begin
          left = $urandom_range(1, 16);
          gap = 0;
          if (gaps_on) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 70)
                                              : $urandom_range(0, 12);
          end
          // drop valid only for a real gap, so it never falls and rises in one step
          if (gap > 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end
    plan.delete();
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned raw;
    int unsigned n;
    int unsigned total;
    int unsigned phase;
    int unsigned picks [8];
    picks = '{1, 256, 0, 511, 257, 2, 255, 128};
    total = 0;
    phase = 0;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    action_i   <= 1'b0;
    sample_i   <= '0;
    cfg_we_i   <= 1'b0;
    cfg_data_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset length of 256 on the cleared ring, then full-scale and zero primes
    queue_word(OP_SAMPLE, FULL_SCALE);
    queue_word(OP_SAMPLE, '0);
    queue_word(OP_PRIME, FULL_SCALE);
    queue_word(OP_SAMPLE, '0);
    queue_word(OP_PRIME, '0);
    queue_word(OP_SAMPLE, FULL_SCALE);
    play_plan(1'b1, 1'b0);

    // Zero saturates to a window of one
    write_length(0);
    queue_word(OP_PRIME, 14'd12345);
    queue_word(OP_SAMPLE, '0);
    queue_word(OP_SAMPLE, FULL_SCALE);
    play_plan(1'b1, 1'b0);

    // Oversized write saturates to 256; then shrink without priming, so the
    // sum is far too big for the window and the average clamps at full scale
    write_length(511);
    queue_word(OP_PRIME, FULL_SCALE);
    play_plan(1'b0, 1'b0);
    write_length(2);
    queue_word(OP_SAMPLE, 14'd1);
    queue_word(OP_SAMPLE, 14'd5);
    play_plan(1'b1, 1'b0);

    // Short prime keeps the upper entries; growing the window then pulls a
    // stale full-scale entry out of a small sum, which wraps the adder
    queue_word(OP_PRIME, '0);
    play_plan(1'b0, 1'b0);
    write_length(257);
    queue_word(OP_SAMPLE, 14'd7);
    queue_word(OP_SAMPLE, 14'd9);
    queue_word(OP_SAMPLE, FULL_SCALE);
    play_plan(1'b1, 1'b0);

    // Back-to-back length writes, then alternating bit patterns
    write_length(256);
    write_length(3);
    queue_word(OP_PRIME, 14'h2aaa);
    queue_word(OP_SAMPLE, 14'h1555);
    queue_word(OP_SAMPLE, FULL_SCALE);
    queue_word(OP_SAMPLE, '0);
    play_plan(1'b1, 1'b0);

    // Random phases: new length each time, mostly primed first, mostly samples
    while (total < RANDOM_WORDS) begin
      if (phase < 8) begin
        raw = picks[phase];
      end else begin
        case ($urandom_range(0, 9))
          0, 1: raw = $urandom_range(0, 511);
          2, 3, 4: raw = $urandom_range(1, 256);
          default: raw = $urandom_range(1, 16);
        endcase
      end
      write_length(raw);
      n = $urandom_range(60, 160);
      if ($urandom_range(0, 6) != 0) queue_word(OP_PRIME, pick_sample());
      for (int k = 0; k < n; k++) begin
        queue_word(($urandom_range(0, 7) == 0) ? OP_PRIME : OP_SAMPLE, pick_sample());
      end
      total += plan.size();
      play_plan($urandom_range(0, 3) != 0, (phase % 3) == 0);
      phase++;
    end

    // Let any stray average word show up before judging
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      report_mismatch($sformatf("%0d averages never arrived", sb.pending()));
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
